### rtl/core/cml_pkg.sv
// Shared constants and types for the complex magnitude limiter.
package cml_pkg;

  // Default sample width, signed Q1.(SAMPLE_WIDTH-1).
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Gain register: unsigned Q8.8.
  localparam int GAIN_WIDTH = 16;
  localparam int GAIN_FRAC = 8;
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd256;

  // Control bits that travel down the pipeline alongside each sample.
  typedef struct packed {
    logic valid;
    logic neg;
    logic clip;
  } cml_tag_t;

endpackage

### rtl/core/cml_in_if.sv
// Input channel carrying one complex sample per transaction.
interface cml_in_if #(
  parameter int SAMPLE_WIDTH = cml_pkg::SAMPLE_WIDTH_DEF
) ();

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_re;
  logic signed [SAMPLE_WIDTH-1:0] sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink (input valid, input sample_re, input sample_im, output ready);

endinterface

### rtl/core/cml_out_if.sv
// Output channel carrying one limited real sample per transaction.
interface cml_out_if #(
  parameter int SAMPLE_WIDTH = cml_pkg::SAMPLE_WIDTH_DEF
) ();

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_re;

  modport source (output valid, output out_re, input ready);
  modport sink (input valid, input out_re, output ready);

endinterface

### rtl/core/cml_sqrt_stage.sv
// One registered step of the digit-by-digit integer square root.
module cml_sqrt_stage #(
  parameter int SAMPLE_WIDTH = cml_pkg::SAMPLE_WIDTH_DEF,
  parameter int K = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  cml_pkg::cml_tag_t           tag_i,
  input  logic [2*SAMPLE_WIDTH-1:0]   x_i,
  input  logic [SAMPLE_WIDTH+1:0]     rem_i,
  input  logic [SAMPLE_WIDTH-1:0]     root_i,
  input  logic [SAMPLE_WIDTH-1:0]     re_mag_i,
  output cml_pkg::cml_tag_t           tag_o,
  output logic [2*SAMPLE_WIDTH-1:0]   x_o,
  output logic [SAMPLE_WIDTH+1:0]     rem_o,
  output logic [SAMPLE_WIDTH-1:0]     root_o,
  output logic [SAMPLE_WIDTH-1:0]     re_mag_o
);

  localparam int W = SAMPLE_WIDTH;
  localparam int Hi = 2 * (W - 1 - K) + 1;

  logic [W+3:0] rem_sh;
  logic [W+3:0] trial;
  logic         ge;
  logic [W+3:0] rem_sub;
  logic [W+1:0] rem_d;
  logic [W-1:0] root_d;

  // Bring down the next pair of radicand bits and try 4*root+1.
  assign rem_sh  = {rem_i, x_i[Hi -: 2]};
  assign trial   = {2'b00, root_i, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;
  assign rem_d   = ge ? rem_sub[W+1:0] : rem_sh[W+1:0];
  assign root_d  = {root_i[W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o      <= x_i;
      rem_o    <= rem_d;
      root_o   <= root_d;
      re_mag_o <= re_mag_i;
    end
  end

endmodule

### rtl/core/cml_div_stage.sv
// One registered step of the restoring divider, producing quotient bit K.
module cml_div_stage #(
  parameter int SAMPLE_WIDTH = cml_pkg::SAMPLE_WIDTH_DEF,
  parameter int K = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  cml_pkg::cml_tag_t       tag_i,
  input  logic [SAMPLE_WIDTH-1:0] rem_i,
  input  logic [SAMPLE_WIDTH-1:0] q_i,
  input  logic [SAMPLE_WIDTH-1:0] mag_i,
  input  logic [SAMPLE_WIDTH-1:0] gres_i,
  input  logic                    shift_in_i,
  output cml_pkg::cml_tag_t       tag_o,
  output logic [SAMPLE_WIDTH-1:0] rem_o,
  output logic [SAMPLE_WIDTH-1:0] q_o,
  output logic [SAMPLE_WIDTH-1:0] mag_o,
  output logic [SAMPLE_WIDTH-1:0] gres_o
);

  localparam int W = SAMPLE_WIDTH;

  logic [W:0]   r2;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_d;
  logic [W-1:0] q_d;

  assign r2    = {rem_i, shift_in_i};
  assign ge    = r2 >= {1'b0, mag_i};
  assign diff  = r2 - {1'b0, mag_i};
  assign rem_d = ge ? diff[W-1:0] : r2[W-1:0];

  always_comb begin
    q_d    = q_i;
    q_d[K] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      q_o    <= q_d;
      mag_o  <= mag_i;
      gres_o <= gres_i;
    end
  end

endmodule

### rtl/core/cml_out_buf.sv
// Output register with a skid slot that decouples the pipeline from the sink.
module cml_out_buf #(
  parameter int SAMPLE_WIDTH = cml_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [SAMPLE_WIDTH-1:0] data_i,
  output logic                    en_o,
  cml_out_if.source               result_o
);

  localparam int W = SAMPLE_WIDTH;

  logic [W-1:0] main_d, main_q;
  logic [W-1:0] skid_d, skid_q;
  logic         main_vld_d, main_vld_q;
  logic         skid_vld_d, skid_vld_q;
  logic         take;
  logic         push;

  // The pipeline only advances while the skid slot is free.
  assign en_o = !skid_vld_q;
  assign take = main_vld_q && result_o.ready;
  assign push = en_o && valid_i;

  always_comb begin
    main_d     = main_q;
    skid_d     = skid_q;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    if (!main_vld_q || take) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        main_d     = data_i;
        main_vld_d = push;
      end
    end else if (push) begin
      skid_d     = data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign result_o.valid  = main_vld_q;
  assign result_o.out_re = main_q;

endmodule

### rtl/core/complex_magnitude_limiter_core.sv
// Stage order: stages 1 to 3, square root, stages 4 and 5, divider, output register.
// Throughput: one sample per cycle when not stalled; the square root and the divider
// each resolve one result bit per pipeline stage, so the depth grows with SAMPLE_WIDTH.
// A stalled sink holds the whole pipeline once the output skid slot has filled.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and sets gain to 1.0.
// Top level of the complex magnitude limiter.
module complex_magnitude_limiter_core #(
  parameter int SAMPLE_WIDTH = cml_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cml_pkg::GAIN_WIDTH-1:0] cfg_wdata_i,
  cml_in_if.sink                         sample_i,
  cml_out_if.source                      result_o
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int F     = W - 1;
  localparam int SqW   = 2 * W;
  localparam int ProdW = W + cml_pkg::GAIN_WIDTH;

  // Gain times magnitude above this means the envelope exceeds 1.0.
  localparam logic [ProdW-1:0] Unity  = ProdW'(1) << (F + cml_pkg::GAIN_FRAC);
  // Largest magnitude either path can hand on: exactly 1.0 in raw units.
  localparam logic [ProdW-1:0] LimWide = ProdW'(1) << F;
  localparam logic [W-1:0]     Lim    = W'(1) << F;
  localparam logic [W-1:0]     PosMax = Lim - W'(1);

  // Gain register. Software writes it only while the pipeline is empty, so every
  // sample in flight sees the same value; the block itself does not enforce this.
  logic [cml_pkg::GAIN_WIDTH-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= cml_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // Global advance enable. It is driven from a registered flag in the output
  // buffer, so the ready path never runs through the pipeline.
  logic en;

  assign sample_i.ready = en;

  // Stage 1: split both parts into magnitude and sign.
  cml_pkg::cml_tag_t p1_tag_q;
  logic [W-1:0]      p1_re_mag_q, p1_im_mag_q;
  logic [W-1:0]      re_mag_d, im_mag_d;

  assign re_mag_d = sample_i.sample_re[W-1] ? (~sample_i.sample_re + W'(1))
                                            : sample_i.sample_re;
  assign im_mag_d = sample_i.sample_im[W-1] ? (~sample_i.sample_im + W'(1))
                                            : sample_i.sample_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_tag_q <= '0;
    end else if (en) begin
      p1_tag_q <= '{valid: sample_i.valid, neg: sample_i.sample_re[W-1], clip: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_re_mag_q <= re_mag_d;
      p1_im_mag_q <= im_mag_d;
    end
  end

  // Stage 2: square each part.
  cml_pkg::cml_tag_t p2_tag_q;
  logic [SqW-1:0]    p2_sq_re_q, p2_sq_im_q;
  logic [W-1:0]      p2_re_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_tag_q <= '0;
    end else if (en) begin
      p2_tag_q <= p1_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_sq_re_q  <= SqW'(p1_re_mag_q) * SqW'(p1_re_mag_q);
      p2_sq_im_q  <= SqW'(p1_im_mag_q) * SqW'(p1_im_mag_q);
      p2_re_mag_q <= p1_re_mag_q;
    end
  end

  // Stage 3: sum of squares. It cannot exceed 2^(2F+1), so 2W bits suffice.
  cml_pkg::cml_tag_t p3_tag_q;
  logic [SqW-1:0]    p3_sumsq_q;
  logic [W-1:0]      p3_re_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_tag_q <= '0;
    end else if (en) begin
      p3_tag_q <= p2_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_sumsq_q  <= p2_sq_re_q + p2_sq_im_q;
      p3_re_mag_q <= p2_re_mag_q;
    end
  end

  // Square root: W stages, each resolving one root bit from the most
  // significant down. The root is below 2^W because the sum of squares is.
  cml_pkg::cml_tag_t sq_tag    [0:W];
  logic [SqW-1:0]    sq_x      [0:W-1];
  logic [W+1:0]      sq_rem    [0:W-1];
  logic [W-1:0]      sq_root   [0:W];
  logic [W-1:0]      sq_re_mag [0:W];

  assign sq_tag[0]    = p3_tag_q;
  assign sq_x[0]      = p3_sumsq_q;
  assign sq_rem[0]    = '0;
  assign sq_root[0]   = '0;
  assign sq_re_mag[0] = p3_re_mag_q;

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    if (i == W - 1) begin : g_last
      cml_sqrt_stage #(
        .SAMPLE_WIDTH(W),
        .K           (i)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .tag_i   (sq_tag[i]),
        .x_i     (sq_x[i]),
        .rem_i   (sq_rem[i]),
        .root_i  (sq_root[i]),
        .re_mag_i(sq_re_mag[i]),
        .tag_o   (sq_tag[i+1]),
        .x_o     (),
        .rem_o   (),
        .root_o  (sq_root[i+1]),
        .re_mag_o(sq_re_mag[i+1])
      );
    end else begin : g_mid
      cml_sqrt_stage #(
        .SAMPLE_WIDTH(W),
        .K           (i)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .tag_i   (sq_tag[i]),
        .x_i     (sq_x[i]),
        .rem_i   (sq_rem[i]),
        .root_i  (sq_root[i]),
        .re_mag_i(sq_re_mag[i]),
        .tag_o   (sq_tag[i+1]),
        .x_o     (sq_x[i+1]),
        .rem_o   (sq_rem[i+1]),
        .root_o  (sq_root[i+1]),
        .re_mag_o(sq_re_mag[i+1])
      );
    end
  end

  // Stage 4: the two gain products, computed side by side.
  cml_pkg::cml_tag_t p4_tag_q;
  logic [ProdW-1:0]  p4_prod_cmp_q, p4_prod_gain_q;
  logic [W-1:0]      p4_mag_q, p4_re_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_tag_q <= '0;
    end else if (en) begin
      p4_tag_q <= sq_tag[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_prod_cmp_q  <= ProdW'(gain_q) * ProdW'(sq_root[W]);
      p4_prod_gain_q <= ProdW'(sq_re_mag[W]) * ProdW'(gain_q);
      p4_mag_q       <= sq_root[W];
      p4_re_mag_q    <= sq_re_mag[W];
    end
  end

  // Stage 5: decide the path and clamp the gain-path result to 1.0. A zero
  // magnitude never passes the threshold, so the divider never sees zero
  // on a sample whose quotient is used.
  cml_pkg::cml_tag_t p5_tag_q;
  logic [W-1:0]      p5_gres_q, p5_mag_q, p5_re_mag_q;
  logic [ProdW-1:0]  gain_shifted;
  logic [W-1:0]      gres_d;

  assign gain_shifted = p4_prod_gain_q >> cml_pkg::GAIN_FRAC;
  assign gres_d       = (gain_shifted > LimWide) ? Lim : gain_shifted[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_tag_q <= '0;
    end else if (en) begin
      p5_tag_q <= '{valid: p4_tag_q.valid, neg: p4_tag_q.neg,
                    clip: (p4_prod_cmp_q > Unity)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_gres_q   <= gres_d;
      p5_mag_q    <= p4_mag_q;
      p5_re_mag_q <= p4_re_mag_q;
    end
  end

  // Divider for |re| * 2^F / mag: W stages, one quotient bit each. The
  // magnitude is never below |re|, so the upper dividend bits |re| >> 1 start
  // out below the divisor and the quotient fits in W bits.
  cml_pkg::cml_tag_t dv_tag  [0:W];
  logic [W-1:0]      dv_rem  [0:W-1];
  logic [W-1:0]      dv_q    [0:W];
  logic [W-1:0]      dv_mag  [0:W-1];
  logic [W-1:0]      dv_gres [0:W];

  assign dv_tag[0]  = p5_tag_q;
  assign dv_rem[0]  = p5_re_mag_q >> 1;
  assign dv_q[0]    = '0;
  assign dv_mag[0]  = p5_mag_q;
  assign dv_gres[0] = p5_gres_q;

  for (genvar j = 0; j < W; j++) begin : g_div
    if (j == W - 1) begin : g_last
      cml_div_stage #(
        .SAMPLE_WIDTH(W),
        .K           (W - 1 - j)
      ) u_stage (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .en_i      (en),
        .tag_i     (dv_tag[j]),
        .rem_i     (dv_rem[j]),
        .q_i       (dv_q[j]),
        .mag_i     (dv_mag[j]),
        .gres_i    (dv_gres[j]),
        .shift_in_i((j == 0) ? p5_re_mag_q[0] : 1'b0),
        .tag_o     (dv_tag[j+1]),
        .rem_o     (),
        .q_o       (dv_q[j+1]),
        .mag_o     (),
        .gres_o    (dv_gres[j+1])
      );
    end else begin : g_mid
      cml_div_stage #(
        .SAMPLE_WIDTH(W),
        .K           (W - 1 - j)
      ) u_stage (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .en_i      (en),
        .tag_i     (dv_tag[j]),
        .rem_i     (dv_rem[j]),
        .q_i       (dv_q[j]),
        .mag_i     (dv_mag[j]),
        .gres_i    (dv_gres[j]),
        .shift_in_i((j == 0) ? p5_re_mag_q[0] : 1'b0),
        .tag_o     (dv_tag[j+1]),
        .rem_o     (dv_rem[j+1]),
        .q_o       (dv_q[j+1]),
        .mag_o     (dv_mag[j+1]),
        .gres_o    (dv_gres[j+1])
      );
    end
  end

  // Final selection, sign and saturation. Both paths deliver at most 1.0,
  // which is representable only when negative; positive 1.0 becomes the
  // largest positive code.
  logic [W-1:0] sel_mag;
  logic [W-1:0] final_d;

  assign sel_mag = dv_tag[W].clip ? dv_q[W] : dv_gres[W];
  assign final_d = dv_tag[W].neg ? (~sel_mag + W'(1))
                                 : (sel_mag[F] ? PosMax : sel_mag);

  cml_out_buf #(
    .SAMPLE_WIDTH(W)
  ) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_tag[W].valid),
    .data_i  (final_d),
    .en_o    (en),
    .result_o(result_o)
  );

`ifndef SYNTHESIS
  // The pipeline may only stall while a result is on offer at the output.
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> result_o.valid)
    else $error("pipeline stalled with no result on offer");

  // A stall persists until the sink takes the waiting result.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sample_i.ready && !result_o.ready) |=> !sample_i.ready)
    else $error("stall released without an output transaction");

  // The clip path is never chosen for a zero magnitude.
  a_clip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p5_tag_q.valid && p5_tag_q.clip) |-> (p5_mag_q != '0))
    else $error("clip path selected with zero magnitude");

  // A clipped quotient never exceeds unity.
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_tag[W].valid && dv_tag[W].clip) |-> (dv_q[W] <= Lim))
    else $error("clip quotient above unity");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for the complex magnitude limiter core.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = cml_pkg::SAMPLE_WIDTH_DEF;
  localparam int FRAC = SW - 1;
  localparam int GW = cml_pkg::GAIN_WIDTH;
  localparam int GF = cml_pkg::GAIN_FRAC;
  // Pipeline depth of the core, plus a small margin.
  localparam int LATENCY = 2 * SW + 6 + 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 12;
  localparam int RANDOM_PER_PHASE = 157;
  localparam int MAX_REPORTS = 10;
  localparam int MAX_MAG = 46340;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
  } iq_sample_t;

  // Receiver behaviour: each mode lasts for a random stretch of cycles.
  typedef enum int {
    SINK_ALWAYS,
    SINK_PERIODIC,
    SINK_RANDOM,
    SINK_LONG_STALL
  } sink_mode_e;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [GW-1:0] cfg_wdata_i;

  cml_in_if  #(.SAMPLE_WIDTH(SW)) sample_if ();
  cml_out_if #(.SAMPLE_WIDTH(SW)) result_if ();

  complex_magnitude_limiter_core #(
    .SAMPLE_WIDTH(SW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  // Samples waiting to be offered; the head is the one on the bus while valid is high.
  iq_sample_t           pending_samples_q[$];
  // Limited real outputs predicted for accepted samples, oldest first.
  logic signed [SW-1:0] limited_re_q[$];
  // Our own copy of the gain register.
  logic [GW-1:0]        gain_copy;

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned mode_left;
  int unsigned sink_cycle;
  sink_mode_e  sink_mode;

  logic signed [SW-1:0] corner_vals [6] = '{
    SW'(-(2 ** (SW - 1))), SW'(-(2 ** (SW - 1)) + 1), SW'(-1), SW'(0), SW'(1),
    SW'((2 ** (SW - 1)) - 1)
  };
  logic [GW-1:0] phase_gains [10] = '{
    16'd256, 16'd512, 16'd0, 16'd65535, 16'd1, 16'd128, 16'd255, 16'd257, 16'd384,
    16'd4096
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Integer square root, rounded down, one result bit per iteration.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem = x;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Expected real output for one sample under the given gain.
  function automatic logic signed [SW-1:0] limit_sample(input logic signed [SW-1:0] re,
                                                         input logic signed [SW-1:0] im,
                                                         input logic [GW-1:0] gain);
    logic [63:0] re_abs;
    logic [63:0] im_abs;
    logic [63:0] mag;
    logic [63:0] res;
    re_abs = {{(64 - SW){1'b0}}, re};
    im_abs = {{(64 - SW){1'b0}}, im};
    if (re[SW-1]) re_abs = (64'd1 << SW) - re_abs;
    if (im[SW-1]) im_abs = (64'd1 << SW) - im_abs;
    mag = floor_sqrt(re_abs * re_abs + im_abs * im_abs);
    // Above unity the sample is pulled onto the unit envelope, otherwise plain gain.
    if ({48'd0, gain} * mag > (64'd1 << (FRAC + GF))) begin
      res = (re_abs << FRAC) / mag;
    end else begin
      res = (re_abs * {48'd0, gain}) >> GF;
    end
    if (re[SW-1]) begin
      if (res > (64'd1 << FRAC)) res = 64'd1 << FRAC;
      return SW'(64'd0 - res);
    end
    if (res > (64'd1 << FRAC) - 64'd1) res = (64'd1 << FRAC) - 64'd1;
    return SW'(res);
  endfunction

  // Write the gain register; only called while the core is idle.
  task automatic load_gain(input logic [GW-1:0] gain);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= gain;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_copy = gain;
  endtask

  // Queue one phase of stimulus: optionally the directed corners, then random samples.
  task automatic fill_phase(input logic [GW-1:0] gain, input bit directed, input int count);
    iq_sample_t  s;
    logic [63:0] target;
    logic [63:0] ra;
    logic [63:0] ia;
    iq_sample_t  corners [12];
    corners = '{
      '{16'sd0, 16'sd0}, '{16'sd32767, 16'sd0}, '{-16'sd32768, 16'sd0},
      '{16'sd32767, 16'sd32767}, '{-16'sd32768, -16'sd32768}, '{-16'sd32768, 16'sd32767},
      '{16'sd0, -16'sd32768}, '{16'sd1, 16'sd0}, '{-16'sd1, 16'sd0}, '{16'sd1, -16'sd1},
      '{-16'sd23170, 16'sd23170}, '{16'sd12345, -16'sd6789}
    };
    @(negedge clk_i);
    if (directed) begin
      foreach (corners[k]) pending_samples_q.push_back(corners[k]);
    end
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          s.re = SW'($urandom);
          s.im = SW'($urandom);
        end
        3: begin
          s.re = SW'($urandom_range(0, 510)) - SW'(255);
          s.im = SW'($urandom_range(0, 510)) - SW'(255);
        end
        4: begin
          s.re = SW'($urandom);
          s.im = '0;
        end
        5: begin
          s.re = corner_vals[$urandom_range(0, 5)];
          s.im = corner_vals[$urandom_range(0, 5)];
        end
        default: begin
          // Aim at the clipping threshold, where gain times magnitude is close to unity.
          target = (gain == 0) ? 64'(MAX_MAG + 1)
                               : ((64'd1 << (FRAC + GF)) / gain) + $urandom_range(0, 4);
          target = (target < 2) ? 64'd0 : target - 2;
          if (target > MAX_MAG) begin
            s.re = SW'($urandom);
            s.im = SW'($urandom);
          end else begin
            ra = $urandom_range(0, (target > 32767) ? 32767 : int'(target));
            ia = floor_sqrt(target * target - ra * ra);
            if (ia > 32767) ia = 32767;
            s.re = $urandom_range(0, 1) ? -SW'(ra) : SW'(ra);
            s.im = $urandom_range(0, 1) ? -SW'(ia) : SW'(ia);
          end
        end
      endcase
      pending_samples_q.push_back(s);
    end
  endtask

  // Wait until every queued sample has gone through and its result has been checked.
  task automatic drain();
    while (pending_samples_q.size() != 0 || limited_re_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [GW-1:0] gain;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    sample_if.valid = 1'b0;
    sample_if.sample_re = '0;
    sample_if.sample_im = '0;
    result_if.ready = 1'b0;
    gain_copy = cml_pkg::GAIN_RESET;
    error_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Phases run through fixed gains, the extremes among them, then two random ones.
    for (int p = 0; p < NUM_PHASES; p++) begin
      gain = (p < 10) ? phase_gains[p] : GW'($urandom);
      load_gain(gain);
      fill_phase(gain, p < 2, RANDOM_PER_PHASE);
      drain();
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Driver: offers queued samples in bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        limited_re_q.push_back(limit_sample(sample_if.sample_re, sample_if.sample_im,
                                            gain_copy));
        void'(pending_samples_q.pop_front());
      end
      if (sample_if.valid && !sample_if.ready) begin
        // A stalled transaction holds its payload until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        sample_if.valid <= 1'b0;
      end else if (pending_samples_q.size() != 0) begin
        sample_if.valid <= 1'b1;
        sample_if.sample_re <= pending_samples_q[0].re;
        sample_if.sample_im <= pending_samples_q[0].im;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 7) == 0 ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
        end
        burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
            8: gap_left = $urandom_range(5, 15);
            default: gap_left = $urandom_range(20, 40);
          endcase
        end
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a stall pattern that changes every so often.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      mode_left = 0;
      sink_cycle = 0;
      sink_mode = SINK_ALWAYS;
    end else begin
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      sink_cycle++;
      case (sink_mode)
        SINK_ALWAYS: result_if.ready <= 1'b1;
        SINK_PERIODIC: result_if.ready <= (sink_cycle % 4) != 3;
        SINK_RANDOM: result_if.ready <= 1'($urandom_range(0, 1));
        default: result_if.ready <= (sink_cycle % 32) >= 20;
      endcase
    end
  end

  // Monitor: each result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (limited_re_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result %0d arrived with nothing expected", $realtime, result_if.out_re);
      end else if (result_if.out_re !== limited_re_q[0]) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: out_re mismatch, expected %0d, got %0d", $realtime, limited_re_q[0],
                   result_if.out_re);
        void'(limited_re_q.pop_front());
      end else begin
        void'(limited_re_q.pop_front());
      end
    end
  end

  // Watchdog: the run is abandoned after too many cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((sample_if.valid && sample_if.ready) ||
                 (result_if.valid && result_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
